### rtl/fcba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fcba_pkg;

  localparam int NUM_BLOCKS       = 1024;
  localparam int DIR_SLOTS        = 16;
  localparam int FIRST_DATA_BLOCK = 43;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int LINK_W = BLK_W + 1;
  localparam int DIR_W  = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int NAME_W = 48;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 3;

  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EXISTS   = 3'd1;
  localparam logic [ST_W-1:0] ST_DIRFULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOFILE   = 3'd3;
  localparam logic [ST_W-1:0] ST_DISKFULL = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTIN    = 3'd5;

  // Power-up contents of one table entry.
  function automatic logic [LINK_W-1:0] init_entry(input logic [BLK_W-1:0] idx);
    logic [LINK_W-1:0] r;
    if (idx == '0) begin
      r = (FIRST_DATA_BLOCK < NUM_BLOCKS) ? LINK_W'(FIRST_DATA_BLOCK) : '0;
    end else if (int'(idx) < FIRST_DATA_BLOCK) begin
      r = LINK_W'(NUM_BLOCKS);
    end else if (int'(idx) + 1 < NUM_BLOCKS) begin
      r = LINK_W'(idx) + LINK_W'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/fcba_tbl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fcba_tbl_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [fcba_pkg::BLK_W-1:0]  waddr,
  input  wire logic [fcba_pkg::LINK_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [fcba_pkg::BLK_W-1:0]  raddr,
  output logic      [fcba_pkg::LINK_W-1:0] rdata
);
  import fcba_pkg::*;

  logic [LINK_W-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/fat_chain_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: create/first scan all 16 directory slots, then dispatch and done; a zero name
// or an undefined action goes straight to done. Chain walks pass a test and a read-wait state
// per link for check/next/free and the S_AP_W state alone for append; freeing a block other
// than the first walks the chain twice.
// Throughput: one word at a time; next word taken in the cycle after the result is registered.
// Reset: synchronous; directory emptied at once, then a clearing pass rewrites all
// NUM_BLOCKS (1024) allocation table entries while in_stall stays high.
module fat_chain_block_allocator_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [fcba_pkg::ACT_W-1:0]  action,
  input  wire logic [fcba_pkg::NAME_W-1:0] name_key,
  input  wire logic [fcba_pkg::BLK_W-1:0]  block_number,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [fcba_pkg::ST_W-1:0]   status,
  output logic      [fcba_pkg::BLK_W-1:0]  block_out
);
  import fcba_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE    = 19'd1 << 0,
    S_CLEAR   = 19'd1 << 1,
    S_SCAN    = 19'd1 << 2,
    S_DISP    = 19'd1 << 3,
    S_DONE    = 19'd1 << 4,
    S_CH_TEST = 19'd1 << 5,
    S_CH_W    = 19'd1 << 6,
    S_NX_W    = 19'd1 << 7,
    S_FR_FB_W = 19'd1 << 8,
    S_FR_P_W  = 19'd1 << 9,
    S_FR_L_W  = 19'd1 << 10,
    S_FR_RDH  = 19'd1 << 11,
    S_FR_H_W  = 19'd1 << 12,
    S_FR_HEAD = 19'd1 << 13,
    S_AP_HEAD = 19'd1 << 14,
    S_AP_W    = 19'd1 << 15,
    S_AP_RDA  = 19'd1 << 16,
    S_AP_AW   = 19'd1 << 17,
    S_AP_ZERO = 19'd1 << 18
  } state_t;

  state_t state, state_next;

  // Request word and scan results
  logic [ACT_W-1:0]  act, act_next;
  logic [NAME_W-1:0] name, name_next;
  logic [BLK_W-1:0]  blk, blk_next;
  logic [DIR_W-1:0]  scan_idx, scan_idx_next;
  logic              found, found_next;
  logic [DIR_W-1:0]  slot, slot_next;
  logic              empty_found, empty_found_next;
  logic [DIR_W-1:0]  empty_slot, empty_slot_next;

  // Chain walker
  logic [BLK_W-1:0]  cur, cur_next;
  logic [BLK_W-1:0]  alloc, alloc_next;
  logic [LINK_W-1:0] steps, steps_next;
  logic [BLK_W-1:0]  clr, clr_next;

  // Pending result
  logic [ST_W-1:0]   res_status, res_status_next;
  logic [BLK_W-1:0]  res_block, res_block_next;

  // Root directory, flop based
  logic [NAME_W-1:0] dir_names  [DIR_SLOTS];
  logic [BLK_W-1:0]  dir_firsts [DIR_SLOTS];
  logic              dn_we, df_we;
  logic [DIR_W-1:0]  dir_widx;
  logic [BLK_W-1:0]  dir_wfirst;
  logic [BLK_W-1:0]  first_sel;

  // Allocation table port
  logic              tbl_we, tbl_re;
  logic [BLK_W-1:0]  tbl_waddr, tbl_raddr;
  logic [LINK_W-1:0] tbl_wdata, tbl_rdata;
  logic [BLK_W-1:0]  lk;
  logic              more;

  fcba_tbl_ram u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Link values at or above NUM_BLOCKS (reserved mark included) end a chain.
  assign lk        = (tbl_rdata < LINK_W'(NUM_BLOCKS)) ? tbl_rdata[BLK_W-1:0] : '0;
  assign more      = (steps < LINK_W'(NUM_BLOCKS));
  assign first_sel = dir_firsts[slot];
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    act_next         = act;
    name_next        = name;
    blk_next         = blk;
    scan_idx_next    = scan_idx;
    found_next       = found;
    slot_next        = slot;
    empty_found_next = empty_found;
    empty_slot_next  = empty_slot;
    cur_next         = cur;
    alloc_next       = alloc;
    steps_next       = steps;
    clr_next         = clr;
    res_status_next  = res_status;
    res_block_next   = res_block;
    dn_we            = 1'b0;
    df_we            = 1'b0;
    dir_widx         = slot;
    dir_wfirst       = '0;
    tbl_we           = 1'b0;
    tbl_waddr        = '0;
    tbl_wdata        = '0;
    tbl_re           = 1'b0;
    tbl_raddr        = '0;

    unique case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr;
        tbl_wdata = init_entry(clr);
        clr_next  = clr + BLK_W'(1);
        if (clr == BLK_W'(NUM_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_next         = action;
          name_next        = name_key;
          blk_next         = block_number;
          scan_idx_next    = '0;
          found_next       = 1'b0;
          empty_found_next = 1'b0;
          res_block_next   = '0;
          if (action > ACT_FIRST) begin
            res_status_next = ST_OK;
            state_next      = S_DONE;
          end else if (name_key == '0) begin
            res_status_next = ST_NOFILE;
            state_next      = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // One slot a cycle; lowest matching and lowest empty slot win.
        if (!found && dir_names[scan_idx] == name) begin
          found_next = 1'b1;
          slot_next  = scan_idx;
        end
        if (!empty_found && dir_names[scan_idx] == '0) begin
          empty_found_next = 1'b1;
          empty_slot_next  = scan_idx;
        end
        scan_idx_next = scan_idx + DIR_W'(1);
        if (scan_idx == DIR_W'(DIR_SLOTS - 1)) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (act == ACT_CREATE) begin
          state_next = S_DONE;
          if (found) begin
            res_status_next = ST_EXISTS;
          end else if (empty_found) begin
            dn_we           = 1'b1;
            dir_widx        = empty_slot;
            res_status_next = ST_OK;
          end else begin
            res_status_next = ST_DIRFULL;
          end
        end else if (act == ACT_APPEND) begin
          tbl_re     = 1'b1;
          tbl_raddr  = '0;
          state_next = S_AP_HEAD;
        end else if (!found) begin
          res_status_next = ST_NOFILE;
          state_next      = S_DONE;
        end else if (act == ACT_FIRST) begin
          res_status_next = ST_OK;
          res_block_next  = first_sel;
          state_next      = S_DONE;
        end else begin
          cur_next   = first_sel;
          steps_next = '0;
          state_next = S_CH_TEST;
        end
      end
      S_CH_TEST: begin
        if (cur != '0 && more) begin
          if (cur == blk) begin
            if (act == ACT_CHECK) begin
              res_status_next = ST_OK;
              state_next      = S_DONE;
            end else if (act == ACT_NEXT) begin
              tbl_re     = 1'b1;
              tbl_raddr  = blk;
              state_next = S_NX_W;
            end else if (first_sel == blk) begin
              tbl_re     = 1'b1;
              tbl_raddr  = blk;
              state_next = S_FR_FB_W;
            end else begin
              cur_next   = first_sel;
              steps_next = '0;
              tbl_re     = 1'b1;
              tbl_raddr  = first_sel;
              state_next = S_FR_P_W;
            end
          end else begin
            tbl_re     = 1'b1;
            tbl_raddr  = cur;
            state_next = S_CH_W;
          end
        end else begin
          res_status_next = ST_NOTIN;
          state_next      = S_DONE;
        end
      end
      S_CH_W: begin
        cur_next   = lk;
        steps_next = steps + LINK_W'(1);
        state_next = S_CH_TEST;
      end
      S_NX_W: begin
        res_status_next = ST_OK;
        res_block_next  = lk;
        state_next      = S_DONE;
      end
      S_FR_FB_W: begin
        // freeing the first block: directory skips past it
        df_we      = 1'b1;
        dir_wfirst = lk;
        tbl_re     = 1'b1;
        tbl_raddr  = '0;
        state_next = S_FR_H_W;
      end
      S_FR_P_W: begin
        if (lk != blk && lk != '0 && more) begin
          cur_next   = lk;
          steps_next = steps + LINK_W'(1);
          tbl_re     = 1'b1;
          tbl_raddr  = lk;
        end else if (lk == blk) begin
          tbl_re     = 1'b1;
          tbl_raddr  = blk;
          state_next = S_FR_L_W;
        end else begin
          tbl_re     = 1'b1;
          tbl_raddr  = '0;
          state_next = S_FR_H_W;
        end
      end
      S_FR_L_W: begin
        tbl_we     = 1'b1;
        tbl_waddr  = cur;
        tbl_wdata  = LINK_W'(lk);
        state_next = S_FR_RDH;
      end
      S_FR_RDH: begin
        tbl_re     = 1'b1;
        tbl_raddr  = '0;
        state_next = S_FR_H_W;
      end
      S_FR_H_W: begin
        tbl_we     = 1'b1;
        tbl_waddr  = blk;
        tbl_wdata  = LINK_W'(lk);
        state_next = S_FR_HEAD;
      end
      S_FR_HEAD: begin
        tbl_we          = 1'b1;
        tbl_waddr       = '0;
        tbl_wdata       = LINK_W'(blk);
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end
      S_AP_HEAD: begin
        alloc_next = lk;
        if (lk == '0) begin
          res_status_next = ST_DISKFULL;
          state_next      = S_DONE;
        end else if (!found) begin
          res_status_next = ST_NOFILE;
          state_next      = S_DONE;
        end else if (first_sel == '0) begin
          df_we      = 1'b1;
          dir_wfirst = lk;
          state_next = S_AP_RDA;
        end else begin
          cur_next   = first_sel;
          steps_next = '0;
          tbl_re     = 1'b1;
          tbl_raddr  = first_sel;
          state_next = S_AP_W;
        end
      end
      S_AP_W: begin
        if (lk != '0 && more) begin
          cur_next   = lk;
          steps_next = steps + LINK_W'(1);
          tbl_re     = 1'b1;
          tbl_raddr  = lk;
        end else begin
          tbl_we     = 1'b1;
          tbl_waddr  = cur;
          tbl_wdata  = LINK_W'(alloc);
          state_next = S_AP_RDA;
        end
      end
      S_AP_RDA: begin
        tbl_re     = 1'b1;
        tbl_raddr  = alloc;
        state_next = S_AP_AW;
      end
      S_AP_AW: begin
        tbl_we     = 1'b1;
        tbl_waddr  = '0;
        tbl_wdata  = LINK_W'(lk);
        state_next = S_AP_ZERO;
      end
      S_AP_ZERO: begin
        tbl_we          = 1'b1;
        tbl_waddr       = alloc;
        tbl_wdata       = '0;
        res_status_next = ST_OK;
        res_block_next  = alloc;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    act         <= act_next;
    name        <= name_next;
    blk         <= blk_next;
    scan_idx    <= scan_idx_next;
    found       <= found_next;
    slot        <= slot_next;
    empty_found <= empty_found_next;
    empty_slot  <= empty_slot_next;
    cur         <= cur_next;
    alloc       <= alloc_next;
    steps       <= steps_next;
    res_status  <= res_status_next;
    res_block   <= res_block_next;
  end

  // Directory storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIR_SLOTS; i++) begin
        dir_names[i]  <= '0;
        dir_firsts[i] <= '0;
      end
    end else if (dn_we) begin
      dir_names[dir_widx]  <= name;
      dir_firsts[dir_widx] <= '0;
    end else if (df_we) begin
      dir_firsts[dir_widx] <= dir_wfirst;
    end
  end

  // Output register: the next word may be accepted while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status    <= res_status;
      block_out <= res_block;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !tbl_we)
    else $error("table written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CH_W || state == S_AP_W || state == S_FR_P_W) |-> more)
    else $error("chain walk exceeded table size");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR && !out_valid))
    else $error("reset did not start clearing pass");

endmodule
`default_nettype wire

### verif/fat_chain_block_allocator_core_tb.sv
`timescale 1ns / 1ps
module fat_chain_block_allocator_core_tb;
  import fcba_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [BLK_W-1:0] blk;
  } answer_t;

  // Allocator mirror plus the queue of answers still owed by the DUT.
  class fat_scoreboard;
    logic [NAME_W-1:0] names [DIR_SLOTS];
    logic [BLK_W-1:0]  firsts[DIR_SLOTS];
    int unsigned       fat   [NUM_BLOCKS];
    answer_t           owed[$];
    int                errors;
    int                checked;

    function void clear();
      for (int i = 0; i < DIR_SLOTS; i++) begin
        names[i] = '0;
        firsts[i] = '0;
      end
      fat[0] = FIRST_DATA_BLOCK;
      for (int i = 1; i < NUM_BLOCKS; i++)
        fat[i] = (i < FIRST_DATA_BLOCK) ? NUM_BLOCKS : ((i + 1 < NUM_BLOCKS) ? i + 1 : 0);
    endfunction

    // Follow one link; bad links end the chain.
    function int unsigned follow(int unsigned b);
      if (b >= NUM_BLOCKS) return 0;
      return (fat[b] < NUM_BLOCKS) ? fat[b] : 0;
    endfunction

    function int lookup(logic [NAME_W-1:0] nm);
      for (int i = 0; i < DIR_SLOTS; i++)
        if (names[i] == nm) return i;
      return -1;
    endfunction

    function bit owns(int unsigned first, int unsigned b);
      int unsigned p;
      int unsigned n;
      p = first;
      n = 0;
      while (p != 0 && p < NUM_BLOCKS && n < NUM_BLOCKS) begin
        if (p == b) return 1;
        p = follow(p);
        n++;
      end
      return 0;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [NAME_W-1:0] nm,
                               logic [BLK_W-1:0] bn);
      answer_t a;
      int s;
      int unsigned fresh, p, n, first;
      a = '0;
      if (act > ACT_FIRST) begin
        owed = {owed, a};
        return;
      end
      if (nm == '0) begin
        a.st = ST_NOFILE;
        owed = {owed, a};
        return;
      end
      s = lookup(nm);
      case (act)
        ACT_CREATE: begin
          if (s >= 0) a.st = ST_EXISTS;
          else begin
            a.st = ST_DIRFULL;
            for (int i = 0; i < DIR_SLOTS; i++)
              if (names[i] == '0) begin
                names[i] = nm;
                firsts[i] = '0;
                a.st = ST_OK;
                break;
              end
          end
        end
        ACT_APPEND: begin
          fresh = follow(0);
          if (fresh == 0) a.st = ST_DISKFULL;
          else if (s < 0) a.st = ST_NOFILE;
          else begin
            p = firsts[s];
            if (p == 0) firsts[s] = BLK_W'(fresh);
            else begin
              n = 0;
              while (follow(p) != 0 && n < NUM_BLOCKS) begin
                p = follow(p);
                n++;
              end
              fat[p] = fresh;
            end
            fat[0] = follow(fresh);
            fat[fresh] = 0;
            a.blk = BLK_W'(fresh);
          end
        end
        default: begin
          if (s < 0) a.st = ST_NOFILE;
          else if (act == ACT_FIRST) a.blk = firsts[s];
          else if (!owns(firsts[s], bn)) a.st = ST_NOTIN;
          else if (act == ACT_FREE) begin
            first = firsts[s];
            if (first == bn) firsts[s] = BLK_W'(follow(bn));
            else begin
              p = first;
              n = 0;
              while (follow(p) != bn && follow(p) != 0 && n < NUM_BLOCKS) begin
                p = follow(p);
                n++;
              end
              if (follow(p) == bn) fat[p] = follow(bn);
            end
            fat[bn] = follow(0);
            fat[0] = bn;
          end else if (act == ACT_NEXT) a.blk = BLK_W'(follow(bn));
        end
      endcase
      owed = {owed, a};
    endfunction

    function void check_answer(logic [ST_W-1:0] st, logic [BLK_W-1:0] blk);
      answer_t e;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: status %0d block %0d", st, blk);
        return;
      end
      e = owed.pop_front();
      if (e.st !== st || e.blk !== blk) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d block %0d, got status %0d block %0d",
                   e.st, e.blk, st, blk);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0]  action = '0;
  logic [NAME_W-1:0] name_key = '0;
  logic [BLK_W-1:0]  block_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0]  status;
  logic [BLK_W-1:0] block_out;

  fat_scoreboard sb = new();
  logic [NAME_W-1:0] pool[8];
  int sent;

  always #10 clk = ~clk;

  fat_chain_block_allocator_core DUT (.*);

  // Half the time no gap, otherwise mostly short gaps and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: random stall, sample at rising edge.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_answer(status, block_out);

  initial begin
    int g;
    @(negedge clk);
    forever begin
      g = pick_gap();
      out_stall <= (g != 0);
      repeat (g == 0 ? $urandom_range(1, 8) : g) @(negedge clk);
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // Present one word; hold it until accepted.
  task automatic push_word(logic [ACT_W-1:0] act, logic [NAME_W-1:0] nm,
                           logic [BLK_W-1:0] bn);
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    action <= act;
    name_key <= nm;
    block_number <= bn;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, nm, bn);
    sent++;
    @(negedge clk);
  endtask

  // Block that is likely to matter for the named file: in its chain or near it.
  function automatic logic [BLK_W-1:0] near_block(logic [NAME_W-1:0] nm);
    int s;
    int unsigned p;
    int k;
    s = sb.lookup(nm);
    if (s < 0 || sb.firsts[s] == 0 || $urandom_range(0, 4) == 0) return BLK_W'($urandom);
    p = sb.firsts[s];
    k = $urandom_range(0, 6);
    for (int i = 0; i < k; i++)
      if (sb.follow(p) != 0) p = sb.follow(p);
    return BLK_W'(p);
  endfunction

  initial begin
    logic [ACT_W-1:0] a;
    logic [NAME_W-1:0] nm;
    int r;
    sb.clear();
    for (int i = 0; i < 8; i++) pool[i] = NAME_W'({$urandom, $urandom}) | 48'h1;
    pool[0] = '1;
    pool[1] = 48'h1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero name, undefined actions, extremes, foreign free.
    push_word(ACT_FIRST, '0, '0);
    push_word(3'd6, pool[0], '1);
    push_word(3'd7, '0, '0);
    push_word(ACT_APPEND, pool[0], '0);
    push_word(ACT_CREATE, pool[0], '0);
    push_word(ACT_CREATE, pool[0], '0);
    push_word(ACT_FIRST, pool[0], '0);
    push_word(ACT_APPEND, pool[0], '0);
    push_word(ACT_APPEND, pool[0], '0);
    push_word(ACT_NEXT, pool[0], 10'd43);
    push_word(ACT_NEXT, pool[0], 10'd44);
    push_word(ACT_CHECK, pool[0], 10'd44);
    push_word(ACT_CHECK, pool[0], 10'd0);
    push_word(ACT_FREE, pool[0], '1);
    push_word(ACT_FREE, pool[0], 10'd43);
    push_word(ACT_FIRST, pool[0], '0);
    push_word(ACT_CREATE, pool[1], '0);
    push_word(ACT_NEXT, pool[1], 10'd5);
    // Fill the directory to hit directory full.
    for (int i = 0; i < DIR_SLOTS; i++)
      push_word(ACT_CREATE, NAME_W'({$urandom, $urandom}), '0);

    // Random: mostly well-formed work on known files.
    while (sent < 580) begin
      r = $urandom_range(0, 99);
      nm = (r < 90) ? pool[$urandom_range(0, 7)] : NAME_W'({$urandom, $urandom});
      if (r == 99) nm = '0;
      r = $urandom_range(0, 99);
      a = (r < 8) ? ACT_CREATE : (r < 38) ? ACT_APPEND : (r < 58) ? ACT_FREE :
          (r < 70) ? ACT_CHECK : (r < 88) ? ACT_NEXT : (r < 97) ? ACT_FIRST :
          3'($urandom_range(6, 7));
      push_word(a, nm, near_block(nm));
    end
    in_valid <= 1'b0;

    r = 0;
    while (sb.owed.size() != 0 && r < 500000) begin
      @(posedge clk);
      r++;
    end
    repeat (2 * NUM_BLOCKS + 50) @(posedge clk);
    $display("checked %0d answers over create, append, free, check, next, first,",
             sb.checked);
    $display("including directory full, foreign blocks, undefined actions and zero names");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d answers missing", sb.errors, sb.owed.size());
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
